// ----- rtl/ppme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppme_pkg
// Types, micro-op codes and the control store of the perfect power exponent
// unit.
// ----------------------------------------------------------------------------
package ppme_pkg;

	localparam int EXP_W = 5;
	localparam int PC_W  = 4;

	typedef logic [PC_W-1:0] upc_t;

	// control store addresses
	localparam upc_t ADDR_LOAD       = 4'd0;
	localparam upc_t ADDR_START      = 4'd1;
	localparam upc_t ADDR_P_CHECK    = 4'd2;
	localparam upc_t ADDR_SKIP       = 4'd3;
	localparam upc_t ADDR_INIT_ROOT  = 4'd4;
	localparam upc_t ADDR_TRIAL      = 4'd5;
	localparam upc_t ADDR_MUL_LO     = 4'd6;
	localparam upc_t ADDR_MUL_HI     = 4'd7;
	localparam upc_t ADDR_ACCUM      = 4'd8;
	localparam upc_t ADDR_EVAL       = 4'd9;
	localparam upc_t ADDR_KEEP       = 4'd10;
	localparam upc_t ADDR_NEXT_K     = 4'd11;
	localparam upc_t ADDR_NEXT_P     = 4'd12;
	localparam upc_t ADDR_FOUND      = 4'd13;
	localparam upc_t ADDR_EMIT       = 4'd14;
	localparam upc_t ADDR_EMIT_RETRY = 4'd15;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_START_P,
		OP_INIT_ROOT,
		OP_INIT_POW,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ACCUM,
		OP_KEEP_BIT,
		OP_DEC_K,
		OP_DEC_P,
		OP_SET_RES,
		OP_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_INPUT,
		C_M_LT2,
		C_P_LT2,
		C_SKIP_P,
		C_CNT_ZERO,
		C_OVF,
		C_EXACT,
		C_K_NONZERO,
		C_OUT_FREE
	} ucond_t;

	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		upc_t   target;
	} uword_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic m_lt2;
		logic p_lt2;
		logic skip_p;
		logic cnt_zero;
		logic ovf;
		logic exact;
		logic k_nonzero;
	} dp_status_t;

	// microprogram: next address is target when cond holds, else pc + 1
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: ADDR_LOAD};
		unique case (pc)
			ADDR_LOAD:       w = '{op: OP_LOAD,      cond: C_NO_INPUT,  target: ADDR_LOAD};
			ADDR_START:      w = '{op: OP_START_P,   cond: C_M_LT2,     target: ADDR_EMIT};
			ADDR_P_CHECK:    w = '{op: OP_NOP,       cond: C_P_LT2,     target: ADDR_EMIT};
			ADDR_SKIP:       w = '{op: OP_NOP,       cond: C_SKIP_P,    target: ADDR_NEXT_P};
			ADDR_INIT_ROOT:  w = '{op: OP_INIT_ROOT, cond: C_NONE,      target: ADDR_LOAD};
			ADDR_TRIAL:      w = '{op: OP_INIT_POW,  cond: C_NONE,      target: ADDR_LOAD};
			ADDR_MUL_LO:     w = '{op: OP_MUL_LO,    cond: C_CNT_ZERO,  target: ADDR_EVAL};
			ADDR_MUL_HI:     w = '{op: OP_MUL_HI,    cond: C_NONE,      target: ADDR_LOAD};
			ADDR_ACCUM:      w = '{op: OP_ACCUM,     cond: C_ALWAYS,    target: ADDR_MUL_LO};
			ADDR_EVAL:       w = '{op: OP_NOP,       cond: C_OVF,       target: ADDR_NEXT_K};
			ADDR_KEEP:       w = '{op: OP_KEEP_BIT,  cond: C_EXACT,     target: ADDR_FOUND};
			ADDR_NEXT_K:     w = '{op: OP_DEC_K,     cond: C_K_NONZERO, target: ADDR_TRIAL};
			ADDR_NEXT_P:     w = '{op: OP_DEC_P,     cond: C_ALWAYS,    target: ADDR_P_CHECK};
			ADDR_FOUND:      w = '{op: OP_SET_RES,   cond: C_NONE,      target: ADDR_LOAD};
			ADDR_EMIT:       w = '{op: OP_EMIT,      cond: C_OUT_FREE,  target: ADDR_LOAD};
			ADDR_EMIT_RETRY: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ADDR_EMIT};
			default:         w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ADDR_LOAD};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/ppme_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppme_datapath
// Magnitude, exponent and root registers with one shared multiplier, driven
// by one micro-op per cycle.
// ----------------------------------------------------------------------------
module ppme_datapath
	import ppme_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  uop_t                  op,
	input  logic [VALUE_BITS-1:0] value,
	output dp_status_t            status,
	output logic [EXP_W-1:0]      res
);

	// root of any p >= 2 fits in half the width, rounded up
	localparam int H     = (VALUE_BITS + 1) / 2;
	localparam int HI_W  = VALUE_BITS - H;
	localparam int KW    = $clog2(H);
	localparam int PW    = $clog2(VALUE_BITS + 1);
	localparam int SUM_W = VALUE_BITS + H + 1;

	logic [VALUE_BITS-1:0] m_q;
	logic                  neg_q;
	logic [PW-1:0]         p_q;
	logic [PW-1:0]         cnt_q;
	logic [KW-1:0]         k_q;
	logic [H-1:0]          root_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [2*H-1:0]        lo_q;
	logic [VALUE_BITS-1:0] hi_q;
	logic                  ovf_q;
	logic [EXP_W-1:0]      res_q;

	logic [H-1:0]     cand;
	logic [H-1:0]     mul_a;
	logic [2*H-1:0]   mul_p;
	logic [SUM_W-1:0] sum;
	logic             exceed;

	assign cand   = root_q | (H'(1) << k_q);
	assign mul_a  = (op == OP_MUL_HI) ? H'(acc_q[VALUE_BITS-1:H]) : acc_q[H-1:0];
	assign mul_p  = mul_a * cand;
	// acc * cand rebuilt from its two partial products
	assign sum    = {1'b0, hi_q, {H{1'b0}}} + SUM_W'(lo_q);
	assign exceed = sum > SUM_W'(m_q);

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				neg_q <= value[VALUE_BITS-1];
				m_q   <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
				res_q <= EXP_W'(1);
			end
			OP_START_P: begin
				p_q <= PW'(VALUE_BITS);
			end
			OP_INIT_ROOT: begin
				root_q <= '0;
				k_q    <= KW'(H - 1);
			end
			OP_INIT_POW: begin
				acc_q <= VALUE_BITS'(1);
				cnt_q <= p_q;
				ovf_q <= 1'b0;
			end
			OP_MUL_LO: begin
				lo_q <= mul_p;
			end
			OP_MUL_HI: begin
				hi_q <= VALUE_BITS'(mul_p);
			end
			OP_ACCUM: begin
				if (exceed) begin
					ovf_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					acc_q <= sum[VALUE_BITS-1:0];
					cnt_q <= cnt_q - PW'(1);
				end
			end
			OP_KEEP_BIT: begin
				root_q <= cand;
			end
			OP_DEC_K: begin
				k_q <= k_q - KW'(1);
			end
			OP_DEC_P: begin
				p_q <= p_q - PW'(1);
			end
			OP_SET_RES: begin
				res_q <= EXP_W'(p_q);
			end
			default: begin
			end
		endcase
	end

	assign status.m_lt2     = m_q < VALUE_BITS'(2);
	assign status.p_lt2     = p_q < PW'(2);
	assign status.skip_p    = neg_q & ~p_q[0];
	assign status.cnt_zero  = cnt_q == '0;
	assign status.ovf       = ovf_q;
	assign status.exact     = acc_q == m_q;
	assign status.k_nonzero = k_q != '0;
	assign res              = res_q;

	// upper half of acc is never wider than the multiplier operand
	localparam bit HI_FITS = HI_W <= H;
	if (!HI_FITS) begin : g_bad_width
		$error("ppme_datapath: bad width split");
	end

endmodule

// ----- rtl/perfect_power_max_exponent_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_power_max_exponent_unit
// Largest p with value == b^p for an integer |b| >= 2, 1 if there is none;
// negative values only take odd p. Microcoded sequencer over a shared
// multiplier.
// ----------------------------------------------------------------------------
//  channel  valid      stall      payload
//  input    in_valid   in_stall   value     [VALUE_BITS-1:0], signed
//  output   out_valid  out_stall  exponent  [4:0]
//
//  p runs from VALUE_BITS down to 2; each p takes a bitwise root search of
//  H = ceil(VALUE_BITS/2) trials, each trial up to p multiply steps (low
//  product, high product, accumulate) on the one HxH multiplier; magnitudes
//  below 2 skip the search.
//  Reset clears the sequencer and the output valid flag; nothing else is held.
//  A new item is taken only at the load step; the result waits in the output
//  register while the next item is taken.
// ----------------------------------------------------------------------------
module perfect_power_max_exponent_unit
	import ppme_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [EXP_W-1:0]      exponent
);

	upc_t             pc_q;
	logic             out_valid_q;
	logic [EXP_W-1:0] exponent_q;

	uword_t           uw;
	dp_status_t       st;
	logic [EXP_W-1:0] res;
	logic             out_free;
	logic             take;

	assign uw       = ucode_rom(pc_q);
	assign out_free = ~out_valid_q | ~out_stall;

	ppme_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk   (clk),
		.op    (uw.op),
		.value (value),
		.status(st),
		.res   (res)
	);

	always_comb begin
		unique case (uw.cond)
			C_NONE:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = ~in_valid;
			C_M_LT2:     take = st.m_lt2;
			C_P_LT2:     take = st.p_lt2;
			C_SKIP_P:    take = st.skip_p;
			C_CNT_ZERO:  take = st.cnt_zero;
			C_OVF:       take = st.ovf;
			C_EXACT:     take = st.exact;
			C_K_NONZERO: take = st.k_nonzero;
			C_OUT_FREE:  take = out_free;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ADDR_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= take ? uw.target : pc_q + upc_t'(1);
			if (uw.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, no reset needed
	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT && out_free) begin
			exponent_q <= res;
		end
	end

	assign in_stall  = pc_q != ADDR_LOAD;
	assign out_valid = out_valid_q;
	assign exponent  = exponent_q;

`ifndef ASSERT_OFF
	// a new result only appears out of the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q) == ADDR_EMIT)
		else $error("result appeared outside the emit step");

	// an input transfer always starts a new search
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> pc_q == ADDR_START)
		else $error("input transfer did not start a search");

	// exponent is never zero
	a_exp_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exponent != '0)
		else $error("zero exponent on output");

	// the emit step never overwrites a result that is still held
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(exponent))
		else $error("held result overwritten");
`endif

endmodule

// ----- verif/perfect_power_max_exponent_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_power_max_exponent_unit_tb
// Drives signed values into the perfect power exponent unit, predicts the
// largest exponent of each one with a root search of its own and compares
// every returned exponent in order. A directed set covers zero, plus and
// minus one, the most negative value and powers of both signs; the random
// part is mostly exact powers of random base and exponent, some raw words.
// Both sides idle at random; one long output hold backs up the input.
// ----------------------------------------------------------------------------
module perfect_power_max_exponent_unit_tb
	import ppme_pkg::*;
;

	localparam int VALUE_BITS   = 32;
	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUICK_ITEMS  = 8;
	localparam int RANDOM_ITEMS = 110;
	localparam int TAIL_CYCLES  = 30000;
	localparam int CYCLE_LIMIT  = 16000000;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [EXP_W-1:0]      exponent;
	} expected_t;

	class exponent_scoreboard;
		expected_t expected_q[$];
		int        mismatches = 0;

		// largest p with |v| == b^p, b >= 2; negative values take odd p only
		function logic [EXP_W-1:0] max_exponent(logic [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] mag32;
			longint unsigned       mag, lo, hi, mid, acc;
			logic                  found;
			logic [EXP_W-1:0]      best;
			int                    p, i;
			mag32 = v[VALUE_BITS-1] ? -v : v;
			mag   = 64'(mag32);
			best  = EXP_W'(1);
			found = 1'b0;
			if (mag >= 64'd2) begin
				for (p = VALUE_BITS; p >= 2 && !found; p--) begin
					if (!(v[VALUE_BITS-1] && p[0] == 1'b0)) begin
						lo = 64'd2;
						hi = 64'd65536;
						while (lo <= hi && !found) begin
							mid = (lo + hi) / 64'd2;
							acc = 64'd1;
							for (i = 0; i < p && acc <= mag; i++)
								acc = acc * mid;
							if (acc == mag) begin
								found = 1'b1;
								best  = p[EXP_W-1:0];
							end else if (acc > mag) begin
								hi = mid - 64'd1;
							end else begin
								lo = mid + 64'd1;
							end
						end
					end
				end
			end
			return best;
		endfunction

		function void note_value(logic [VALUE_BITS-1:0] v);
			expected_t e;
			e.value    = v;
			e.exponent = max_exponent(v);
			expected_q = {expected_q, e};
		endfunction

		function void check_exponent(logic [EXP_W-1:0] got);
			expected_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("exponent %0d returned with no value pending", got);
			end else begin
				e = expected_q.pop_front();
				if (got !== e.exponent) begin
					mismatches++;
					if (mismatches <= 10)
						$display("value %h: expected exponent %0d, got %0d",
							e.value, e.exponent, got);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [VALUE_BITS-1:0] value     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [EXP_W-1:0]      exponent;

	exponent_scoreboard results = new();
	int                 hold_len   = 0;
	int                 send_calm  = 0;
	int unsigned        cycle_count = 0;

	perfect_power_max_exponent_unit #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.exponent(exponent)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// offer one value and hold it until the transfer happens
	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = $urandom_range(0, 7);
			if ($urandom_range(0, 7) == 0)
				send_calm = $urandom_range(4, 12);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		results.note_value(v);
	endtask

	// result side: random stall before each transfer, or a long hold on request
	initial begin
		int wait_cycles;
		int calm_left;
		calm_left = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_len > 0) begin
				wait_cycles = hold_len;
				hold_len = 0;
			end else if (calm_left > 0) begin
				wait_cycles = 0;
				calm_left--;
			end else begin
				wait_cycles = $urandom_range(0, 7);
				if ($urandom_range(0, 7) == 0)
					calm_left = $urandom_range(4, 12);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			results.check_exponent(exponent);
		end
	end

	initial begin
		logic [VALUE_BITS-1:0] directed[$];
		logic [VALUE_BITS-1:0] v;
		longint unsigned       acc, bmax, base;
		int                    p, n, pick;

		directed = {
			32'd0, 32'd1, -32'd1, 32'd2, -32'd2, 32'd4, -32'd4, -32'd8,
			32'd64, -32'd64, 32'd6, 32'd36, -32'd36,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000,
			32'd65536, 32'd2147395600, 32'd1162261467, -32'd1162261467,
			32'd1977326743, 32'd1000000000, -32'd1000000000, 32'hAAAA_5555
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_value(directed[i]);

		// let everything drain, then hold the output while quick values pile up
		in_valid <= 1'b0;
		@(posedge clk);
		while (results.pending() > 0) @(posedge clk);
		hold_len = HOLD_CYCLES;
		for (n = 0; n < QUICK_ITEMS; n++) begin
			pick = $urandom_range(0, 2);
			send_value(pick == 0 ? 32'd0 : (pick == 1 ? 32'd1 : -32'd1));
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				// exact power: random exponent, base up to the largest that fits, but never below 2
				p = $urandom_range(2, 31);
				bmax = 64'd1;
				do begin
					bmax++;
					acc = 64'd1;
					repeat (p) acc = acc * (bmax + 64'd1);
				end while (acc <= 64'h7FFF_FFFF);
				base = $urandom_range(2, int'(bmax));
				acc = 64'd1;
				repeat (p) acc = acc * base;
				v = acc[VALUE_BITS-1:0];
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end else if (pick < 9) begin
				v = $urandom;
			end else begin
				v = $urandom_range(0, 4) - 2;
			end
			send_value(v);
		end

		in_valid <= 1'b0;
		while (results.pending() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (results.mismatches == 0 && results.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ppme_pkg.sv
rtl/ppme_datapath.sv
rtl/perfect_power_max_exponent_unit.sv
verif/perfect_power_max_exponent_unit_tb.sv
